>>> rtl/hvcc_pkg.sv
`default_nettype none
package hvcc_pkg;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam logic [2:0] OPC_SET       = 3'd0;
  localparam logic [2:0] OPC_CHARGE    = 3'd1;
  localparam logic [2:0] OPC_DISCHARGE = 3'd2;
  localparam logic [2:0] OPC_TICK      = 3'd3;
  localparam logic [2:0] OPC_SAMPLE    = 3'd4;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_REACHED = 3'd1;
  localparam logic [2:0] ST_CTO     = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_SAFE    = 3'd4;
  localparam logic [2:0] ST_DTO     = 3'd5;

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_CHARGE    = 2'd1;
  localparam logic [1:0] PH_DISCHARGE = 2'd2;

  localparam logic [2:0] REG_FULL_SCALE = 3'd0;
  localparam logic [2:0] REG_MAX_VOLTS  = 3'd1;
  localparam logic [2:0] REG_CHG_TMO    = 3'd2;
  localparam logic [2:0] REG_DIS_TMO    = 3'd3;
  localparam logic [2:0] REG_SAFE_VOLTS = 3'd4;

  localparam logic [9:0]  RST_FULL_SCALE = 10'd33;
  localparam logic [9:0]  RST_MAX_VOLTS  = 10'd400;
  localparam logic [15:0] RST_CHG_TMO    = 16'd500;
  localparam logic [15:0] RST_DIS_TMO    = 16'd2000;
  localparam logic [9:0]  RST_SAFE_VOLTS = 10'd5;

  localparam logic [9:0]  MIN_VOLTS = 10'd50;
  localparam logic [11:0] MV_CAP    = 12'd3300;
  localparam logic [12:0] K_273     = 13'd273;

  localparam logic [12:0] R_220  = 13'd4766;
  localparam logic [12:0] R_4095 = 13'd1024;
  localparam logic [12:0] R_20   = 13'd51;
  localparam int          SH_220  = 20;
  localparam int          SH_4095 = 22;
  localparam int          SH_20   = 10;
  localparam logic [11:0] D_220  = 12'd220;
  localparam logic [11:0] D_4095 = 12'd4095;
  localparam logic [11:0] D_20   = 12'd20;

  localparam step_t S_SET    = 5'd0;
  localparam step_t S_CHG    = 5'd10;
  localparam step_t S_REFUSE = 5'd12;
  localparam step_t S_TICK   = 5'd13;
  localparam step_t S_DIS    = 5'd14;
  localparam step_t S_SMP    = 5'd15;
  localparam step_t S_NOP    = 5'd20;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLAMP, OP_MV, OP_MUL, OP_MOVP, OP_FIX, OP_WDRV, OP_WTOL,
    OP_CHARGE, OP_REFUSE, OP_TICK, OP_DISCH, OP_SAMPLE
  } uop_t;

  typedef enum logic [2:0] {C_FS, C_273, C_D220, C_D4095, C_D20} csel_t;

  typedef enum logic [0:0] {J_NONE, J_NOTARGET} jcond_t;

  typedef struct packed {
    uop_t   op;
    csel_t  csel;
    jcond_t jc;
    step_t  jmp;
    logic   last;
  } cw_t;

  function automatic cw_t mk(input uop_t op, input csel_t cs, input logic last);
    cw_t c;
    c.op   = op;
    c.csel = cs;
    c.jc   = J_NONE;
    c.jmp  = '0;
    c.last = last;
    return c;
  endfunction

  function automatic cw_t ucode(input step_t a);
    cw_t c;
    c = mk(OP_NOP, C_FS, 1'b1);
    unique case (a)
      5'd0:  c = mk(OP_CLAMP,  C_FS,    1'b0);
      5'd1:  c = mk(OP_MV,     C_FS,    1'b0);
      5'd2:  c = mk(OP_MUL,    C_273,   1'b0);
      5'd3:  c = mk(OP_MOVP,   C_FS,    1'b0);
      5'd4:  c = mk(OP_MUL,    C_D220,  1'b0);
      5'd5:  c = mk(OP_FIX,    C_D220,  1'b0);
      5'd6:  c = mk(OP_WDRV,   C_FS,    1'b0);
      5'd7:  c = mk(OP_MUL,    C_D20,   1'b0);
      5'd8:  c = mk(OP_FIX,    C_D20,   1'b0);
      5'd9:  c = mk(OP_WTOL,   C_FS,    1'b1);
      5'd10: begin
        c = mk(OP_NOP, C_FS, 1'b0);
        c.jc  = J_NOTARGET;
        c.jmp = S_REFUSE;
      end
      5'd11: c = mk(OP_CHARGE, C_FS,    1'b1);
      5'd12: c = mk(OP_REFUSE, C_FS,    1'b1);
      5'd13: c = mk(OP_TICK,   C_FS,    1'b1);
      5'd14: c = mk(OP_DISCH,  C_FS,    1'b1);
      5'd15: c = mk(OP_MUL,    C_FS,    1'b0);
      5'd16: c = mk(OP_MOVP,   C_FS,    1'b0);
      5'd17: c = mk(OP_MUL,    C_D4095, 1'b0);
      5'd18: c = mk(OP_FIX,    C_D4095, 1'b0);
      5'd19: c = mk(OP_SAMPLE, C_FS,    1'b1);
      default: c = mk(OP_NOP,  C_FS,    1'b1);
    endcase
    return c;
  endfunction

  function automatic step_t entry(input logic [2:0] opc);
    step_t s;
    s = S_NOP;
    unique case (opc)
      OPC_SET:       s = S_SET;
      OPC_CHARGE:    s = S_CHG;
      OPC_DISCHARGE: s = S_DIS;
      OPC_TICK:      s = S_TICK;
      OPC_SAMPLE:    s = S_SMP;
      default:       s = S_NOP;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hvcc_if.sv
`default_nettype none
interface hvcc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [9:0]  voltage_request;
  logic [11:0] adc_sample;
  modport source(output valid, opcode, voltage_request, adc_sample, input ready);
  modport sink(input valid, opcode, voltage_request, adc_sample, output ready);
endinterface

interface hvcc_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] dac_code;
  logic        pump_on;
  logic        charged;
  logic [1:0]  phase;
  logic [9:0]  measured_volts;
  logic [2:0]  status;
  modport source(output valid, dac_code, pump_on, charged, phase, measured_volts, status,
                 input ready);
  modport sink(input valid, dac_code, pump_on, charged, phase, measured_volts, status,
               output ready);
endinterface
`default_nettype wire

>>> rtl/hv_charge_controller.sv
// The single microcode sequencer and its shared 24x13 multiplier handle one command
//   at a time, running it through its microcode steps; a new command is accepted
//   only once the previous one has finished, and a last step waits while an
//   earlier result is still held for res.ready.
// A finished result waits in the output register while the next command runs.
// Reset (rst, synchronous): registers to defaults, state cleared, phase idle.
`default_nettype none
module hv_charge_controller (
  input  logic        clk,
  input  logic        rst,
  hvcc_cmd_if.sink    cmd,
  hvcc_res_if.source  res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [9:0]  fs;
  logic [9:0]  max_volts;
  logic [15:0] chg_tmo;
  logic [15:0] dis_tmo;
  logic [9:0]  safe_volts;

  logic              busy;
  hvcc_pkg::step_t   step, step_next;
  logic [9:0]        req;
  logic [11:0]       smp;
  logic [23:0]       x, x_next;
  logic [36:0]       p, p_next;
  logic [11:0]       q, q_next;

  logic [9:0]  target_volts, target_volts_next;
  logic [5:0]  tol_volts, tol_volts_next;
  logic        charged_flag, charged_flag_next;
  logic [1:0]  phase_reg, phase_reg_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic        pump_running, pump_running_next;
  logic [11:0] drive_code, drive_code_next;
  logic [9:0]  last_volts, last_volts_next;
  logic [2:0]  status_reg, status_next;

  logic        out_valid;
  logic [11:0] out_dac;
  logic        out_pump;
  logic        out_charged;
  logic [1:0]  out_phase;
  logic [9:0]  out_volts;
  logic [2:0]  out_status;

  hvcc_pkg::cw_t cw;
  logic          exec;
  logic          take;
  logic          jump;
  logic [23:0]   mul_a;
  logic [12:0]   mul_b;
  logic [11:0]   q0;
  logic [11:0]   dv;
  logic [23:0]   qd;
  logic [23:0]   rem;
  logic [9:0]    clamp_v;
  logic [15:0]   mv_raw;
  logic [15:0]   mv_q;
  logic [15:0]   e_inc;
  logic [10:0]   lo_sum;
  logic [10:0]   hi_sum;

  assign cw   = hvcc_pkg::ucode(step);
  assign take = cmd.valid && cmd.ready;
  assign exec = busy && (!cw.last || !out_valid || res.ready);
  assign jump = (cw.jc == hvcc_pkg::J_NOTARGET) && (target_volts == 10'd0);

  assign cmd.ready = !busy;

  always_comb begin
    clamp_v = (req < hvcc_pkg::MIN_VOLTS) ? hvcc_pkg::MIN_VOLTS : req;
    if (clamp_v > max_volts) begin
      clamp_v = max_volts;
    end
  end

  assign mv_raw = ({6'd0, x[9:0]} << 5) + {6'd0, x[9:0]};
  assign mv_q   = mv_raw >> 2;

  always_comb begin
    unique case (cw.csel)
      hvcc_pkg::C_FS: begin
        mul_a = {12'd0, smp};
        mul_b = {3'd0, fs};
      end
      hvcc_pkg::C_273: begin
        mul_a = x;
        mul_b = hvcc_pkg::K_273;
      end
      hvcc_pkg::C_D220: begin
        mul_a = x;
        mul_b = hvcc_pkg::R_220;
      end
      hvcc_pkg::C_D4095: begin
        mul_a = x;
        mul_b = hvcc_pkg::R_4095;
      end
      hvcc_pkg::C_D20: begin
        mul_a = x;
        mul_b = hvcc_pkg::R_20;
      end
      default: begin
        mul_a = x;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (cw.csel)
      hvcc_pkg::C_D220: begin
        q0 = p[hvcc_pkg::SH_220 +: 12];
        dv = hvcc_pkg::D_220;
      end
      hvcc_pkg::C_D4095: begin
        q0 = p[hvcc_pkg::SH_4095 +: 12];
        dv = hvcc_pkg::D_4095;
      end
      hvcc_pkg::C_D20: begin
        q0 = p[hvcc_pkg::SH_20 +: 12];
        dv = hvcc_pkg::D_20;
      end
      default: begin
        q0 = '0;
        dv = hvcc_pkg::D_20;
      end
    endcase
  end

  assign qd  = {12'd0, q0} * {12'd0, dv};
  assign rem = x - qd;

  assign e_inc  = (elapsed_ms != 16'hFFFF) ? elapsed_ms + 16'd1 : elapsed_ms;
  assign lo_sum = {1'b0, q[9:0]} + {5'd0, tol_volts};
  assign hi_sum = {1'b0, target_volts} + {5'd0, tol_volts};

  always_comb begin
    step_next          = step;
    x_next             = x;
    p_next             = p;
    q_next             = q;
    target_volts_next  = target_volts;
    tol_volts_next     = tol_volts;
    charged_flag_next  = charged_flag;
    phase_reg_next     = phase_reg;
    elapsed_ms_next    = elapsed_ms;
    pump_running_next  = pump_running;
    drive_code_next    = drive_code;
    last_volts_next    = last_volts;
    status_next        = status_reg;
    if (take) begin
      step_next   = hvcc_pkg::entry(cmd.opcode);
      status_next = hvcc_pkg::ST_NONE;
    end else if (exec) begin
      step_next = jump ? cw.jmp : step + hvcc_pkg::step_t'(1);
      unique case (cw.op)
        hvcc_pkg::OP_NOP: begin
        end
        hvcc_pkg::OP_CLAMP: begin
          target_volts_next = clamp_v;
          x_next            = {14'd0, clamp_v};
        end
        hvcc_pkg::OP_MV: begin
          x_next = (mv_q > {4'd0, hvcc_pkg::MV_CAP}) ? {12'd0, hvcc_pkg::MV_CAP}
                                                   : {8'd0, mv_q};
        end
        hvcc_pkg::OP_MUL: begin
          p_next = {13'd0, mul_a} * {24'd0, mul_b};
        end
        hvcc_pkg::OP_MOVP: begin
          x_next = p[23:0];
        end
        hvcc_pkg::OP_FIX: begin
          q_next = q0 + {11'd0, (rem >= {12'd0, dv})};
        end
        hvcc_pkg::OP_WDRV: begin
          drive_code_next = q;
          x_next          = {14'd0, target_volts};
        end
        hvcc_pkg::OP_WTOL: begin
          tol_volts_next = q[5:0];
        end
        hvcc_pkg::OP_CHARGE: begin
          charged_flag_next = 1'b0;
          pump_running_next = 1'b1;
          phase_reg_next    = hvcc_pkg::PH_CHARGE;
          elapsed_ms_next   = '0;
        end
        hvcc_pkg::OP_REFUSE: begin
          status_next = hvcc_pkg::ST_REFUSED;
        end
        hvcc_pkg::OP_TICK: begin
          if (phase_reg != hvcc_pkg::PH_IDLE) begin
            elapsed_ms_next = e_inc;
            if (phase_reg == hvcc_pkg::PH_CHARGE) begin
              if (e_inc >= chg_tmo) begin
                pump_running_next = 1'b0;
                phase_reg_next    = hvcc_pkg::PH_IDLE;
                status_next       = hvcc_pkg::ST_CTO;
              end
            end else if (e_inc >= dis_tmo) begin
              charged_flag_next = 1'b0;
              target_volts_next = '0;
              tol_volts_next    = '0;
              phase_reg_next    = hvcc_pkg::PH_IDLE;
              status_next       = hvcc_pkg::ST_DTO;
            end
          end
        end
        hvcc_pkg::OP_DISCH: begin
          pump_running_next = 1'b0;
          drive_code_next   = '0;
          phase_reg_next    = hvcc_pkg::PH_DISCHARGE;
          elapsed_ms_next   = '0;
        end
        hvcc_pkg::OP_SAMPLE: begin
          last_volts_next = q[9:0];
          if (phase_reg == hvcc_pkg::PH_CHARGE && elapsed_ms < chg_tmo) begin
            if (lo_sum >= {1'b0, target_volts} && {1'b0, q[9:0]} <= hi_sum) begin
              charged_flag_next = 1'b1;
              phase_reg_next    = hvcc_pkg::PH_IDLE;
              status_next       = hvcc_pkg::ST_REACHED;
            end
          end else if (phase_reg == hvcc_pkg::PH_DISCHARGE && elapsed_ms < dis_tmo) begin
            if (q[9:0] < safe_volts) begin
              charged_flag_next = 1'b0;
              target_volts_next = '0;
              tol_volts_next    = '0;
              phase_reg_next    = hvcc_pkg::PH_IDLE;
              status_next       = hvcc_pkg::ST_SAFE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs         <= hvcc_pkg::RST_FULL_SCALE;
      max_volts  <= hvcc_pkg::RST_MAX_VOLTS;
      chg_tmo    <= hvcc_pkg::RST_CHG_TMO;
      dis_tmo    <= hvcc_pkg::RST_DIS_TMO;
      safe_volts <= hvcc_pkg::RST_SAFE_VOLTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hvcc_pkg::REG_FULL_SCALE: fs         <= cfg_data[9:0];
        hvcc_pkg::REG_MAX_VOLTS:  max_volts  <= cfg_data[9:0];
        hvcc_pkg::REG_CHG_TMO:    chg_tmo    <= cfg_data;
        hvcc_pkg::REG_DIS_TMO:    dis_tmo    <= cfg_data;
        hvcc_pkg::REG_SAFE_VOLTS: safe_volts <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= hvcc_pkg::S_NOP;
      target_volts <= '0;
      tol_volts    <= '0;
      charged_flag <= 1'b0;
      phase_reg    <= hvcc_pkg::PH_IDLE;
      elapsed_ms   <= '0;
      pump_running <= 1'b0;
      drive_code   <= '0;
      last_volts   <= '0;
      status_reg   <= hvcc_pkg::ST_NONE;
      out_valid    <= 1'b0;
    end else begin
      step         <= step_next;
      target_volts <= target_volts_next;
      tol_volts    <= tol_volts_next;
      charged_flag <= charged_flag_next;
      phase_reg    <= phase_reg_next;
      elapsed_ms   <= elapsed_ms_next;
      pump_running <= pump_running_next;
      drive_code   <= drive_code_next;
      last_volts   <= last_volts_next;
      status_reg   <= status_next;
      if (take) begin
        busy <= 1'b1;
      end else if (exec && cw.last) begin
        busy <= 1'b0;
      end
      if (exec && cw.last) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    p <= p_next;
    q <= q_next;
    if (take) begin
      req <= cmd.voltage_request;
      smp <= cmd.adc_sample;
    end
    if (exec && cw.last) begin
      out_dac     <= drive_code_next;
      out_pump    <= pump_running_next;
      out_charged <= charged_flag_next;
      out_phase   <= phase_reg_next;
      out_volts   <= last_volts_next;
      out_status  <= status_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.dac_code       = out_dac;
  assign res.pump_on        = out_pump;
  assign res.charged        = out_charged;
  assign res.phase          = out_phase;
  assign res.measured_volts = out_volts;
  assign res.status         = out_status;

endmodule
`default_nettype wire

>>> rtl/hvcc_checker.sv
`default_nettype none
module hvcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [11:0] dac_code,
  input wire logic        pump_on,
  input wire logic        charged,
  input wire logic [1:0]  phase,
  input wire logic [9:0]  measured_volts,
  input wire logic [2:0]  status
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command port ready right after an accepted beat");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(dac_code) && $stable(pump_on)
      && $stable(charged) && $stable(phase) && $stable(measured_volts) && $stable(status))
    else $error("stalled result beat changed");

  a_no_pump_discharging: assert property (@(posedge clk) disable iff (rst)
    res_valid && phase == hvcc_pkg::PH_DISCHARGE |-> !pump_on)
    else $error("pump running while discharging");

  a_reached_charged: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == hvcc_pkg::ST_REACHED |-> charged && phase == hvcc_pkg::PH_IDLE)
    else $error("target reached without charged flag and idle phase");

endmodule

bind hv_charge_controller hvcc_checker u_hvcc_checker (
  .clk(clk),
  .rst(rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .dac_code(res.dac_code),
  .pump_on(res.pump_on),
  .charged(res.charged),
  .phase(res.phase),
  .measured_volts(res.measured_volts),
  .status(res.status)
);
`default_nettype wire
